>>> hdl/wlcs_pkg.sv
// Types, codes and shared arithmetic for the weighted least-connection selector.
`timescale 1ns / 1ps

package wlcs_pkg;

   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;
   localparam int VAL_W   = 16;
   localparam int OH_W    = 22;
   localparam int PROD_W  = OH_W + VAL_W;

   localparam logic [OH_W-1:0] ACTIVE_FACTOR = 22'd49;

   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_SCHEDULE = 1'b1;

   typedef struct packed {
      logic               func;
      logic [INDEX_W-1:0] entry_index;
      logic [VAL_W-1:0]   active_conns;
      logic [VAL_W-1:0]   ref_count;
      logic [VAL_W-1:0]   server_weight;
   } req_word_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] chosen_index;
      logic [OH_W-1:0]    chosen_overhead;
   } rsp_word_type;

   typedef struct packed {
      logic [VAL_W-1:0] conns;
      logic [VAL_W-1:0] refs;
      logic [VAL_W-1:0] weight;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [OH_W-1:0] overhead_of(input entry_type e);
      overhead_of = OH_W'(e.conns) * ACTIVE_FACTOR + OH_W'(e.refs);
   endfunction

endpackage

>>> hdl/weighted_least_connection_select.sv
// Weighted least-connection selector: server table in RAM and a sequential scan.
// A write word stores its entry and leaves busy low.
// A schedule word scans the active entries in table order and shows a result with found set;
// busy falls in the cycle the result shows. With no active entries the result is all zero.
// Each entry after the first is loaded as a candidate; ST_MUL forms the two cross products, ST_CMP compares.
// Synchronous reset clears the sequencer, the result strobe and active_count; the table is not cleared.
`timescale 1ns / 1ps

module weighted_least_connection_select #(
   parameter int MAX_SERVERS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  wlcs_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   output wlcs_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_wr_en,
   input  logic [wlcs_pkg::COUNT_W-1:0]     csr_wr_data
);
   import wlcs_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SERVERS);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SERVERS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [COUNT_W-1:0] active_count_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] next_ff, next_in;
   logic [OH_W-1:0]    best_oh_ff, best_oh_in;
   logic [VAL_W-1:0]   best_w_ff, best_w_in;
   logic [COUNT_W-1:0] best_idx_ff, best_idx_in;
   logic [OH_W-1:0]    cand_oh_ff, cand_oh_in;
   logic [VAL_W-1:0]   cand_w_ff, cand_w_in;
   logic [COUNT_W-1:0] cand_idx_ff, cand_idx_in;
   logic [PROD_W-1:0]  prod_a_ff, prod_a_in;
   logic [PROD_W-1:0]  prod_b_ff, prod_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   entry_type          ram_wr_data;
   entry_type          ram_rd_data;
   logic [COUNT_W-1:0] count_clamped;
   logic               better;
   logic [OH_W-1:0]    upd_oh;
   logic [VAL_W-1:0]   upd_w;
   logic [COUNT_W-1:0] upd_idx;

   assign ram_wr_data.conns  = req_word.active_conns;
   assign ram_wr_data.refs   = req_word.ref_count;
   assign ram_wr_data.weight = req_word.server_weight;
   assign ram_wr_en = (state_ff == ST_IDLE) && start && (req_word.func == FUNC_WRITE)
                      && (32'(req_word.entry_index) < MAX_SERVERS);

   assign count_clamped = (32'(active_count_ff) > MAX_SERVERS) ? MAX_COUNT : active_count_ff;

   assign better  = prod_a_ff > prod_b_ff;
   assign upd_oh  = better ? cand_oh_ff : best_oh_ff;
   assign upd_w   = better ? cand_w_ff : best_w_ff;
   assign upd_idx = better ? cand_idx_ff : best_idx_ff;

   wlcs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SERVERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_word.entry_index)),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      best_oh_in   = best_oh_ff;
      best_w_in    = best_w_ff;
      best_idx_in  = best_idx_ff;
      cand_oh_in   = cand_oh_ff;
      cand_w_in    = cand_w_ff;
      cand_idx_in  = cand_idx_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_word.func == FUNC_SCHEDULE)) begin
               count_in = count_clamped;
               if (count_clamped == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '0;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_in    = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            best_oh_in  = overhead_of(ram_rd_data);
            best_w_in   = ram_rd_data.weight;
            best_idx_in = '0;
            if (count_ff == COUNT_W'(1)) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.found           = 1'b1;
               rsp_word_in.chosen_index    = '0;
               rsp_word_in.chosen_overhead = overhead_of(ram_rd_data);
               state_in                    = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(COUNT_W'(1));
               next_in     = COUNT_W'(1);
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD, ST_CMP: begin
            if (state_ff == ST_CMP) begin
               best_oh_in  = upd_oh;
               best_w_in   = upd_w;
               best_idx_in = upd_idx;
            end
            if ((state_ff == ST_CMP) && (cand_idx_ff + COUNT_W'(1) == count_ff)) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.found           = 1'b1;
               rsp_word_in.chosen_index    = INDEX_W'(upd_idx);
               rsp_word_in.chosen_overhead = upd_oh;
               state_in                    = ST_IDLE;
            end else begin
               cand_oh_in  = overhead_of(ram_rd_data);
               cand_w_in   = ram_rd_data.weight;
               cand_idx_in = next_ff;
               if (next_ff + COUNT_W'(1) < count_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_W'(next_ff + COUNT_W'(1));
                  next_in     = next_ff + COUNT_W'(1);
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_a_in = PROD_W'(best_oh_ff) * PROD_W'(cand_w_ff);
            prod_b_in = PROD_W'(cand_oh_ff) * PROD_W'(best_w_ff);
            state_in  = ST_CMP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            active_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      next_ff     <= next_in;
      best_oh_ff  <= best_oh_in;
      best_w_ff   <= best_w_in;
      best_idx_ff <= best_idx_in;
      cand_oh_ff  <= cand_oh_in;
      cand_w_ff   <= cand_w_in;
      cand_idx_ff <= cand_idx_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> hdl/wlcs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module wlcs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/wlcs_checker.sv
// Port-level checks for the weighted least-connection selector, bound to the top level.
`timescale 1ns / 1ps

module wlcs_port_checks (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input wlcs_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input wlcs_pkg::rsp_word_type rsp_word
);
   import wlcs_pkg::*;

   // A write word completes at once and never produces a result word.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_word.func == FUNC_WRITE) |=> !busy && !rsp_valid)
      else $error("write word left the block busy or produced a result");

   // A schedule word either starts a scan or answers in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_word.func == FUNC_SCHEDULE) |=> busy || rsp_valid)
      else $error("schedule word was dropped");

   // The end of a scan always delivers a found result.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_word.found)
      else $error("scan ended without a result word");

   // A not-found result reports zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.found |->
         (rsp_word.chosen_index == '0) && (rsp_word.chosen_overhead == '0))
      else $error("not-found result carries nonzero fields");

endmodule

bind weighted_least_connection_select wlcs_port_checks u_wlcs_checker (.*);
